// ===== rtl/srf_pkg.sv =====
// srf_pkg: shared types, constants and helper functions of the scan repulsive force block.
// Used by srf_div, srf_sqrt, srf_cordic and scan_repulsive_force_top; no dependencies.
`timescale 1ns / 1ps
package srf_pkg;

   // scan size and trig precision
   localparam int MAX_BEAMS       = 1024;
   localparam int TRIG_ITERATIONS = 16;
   localparam int BEAM_W          = $clog2(MAX_BEAMS + 1);

   // iterative unit step counts
   localparam int DIV_STEPS  = 40;
   localparam int SQRT_STEPS = 20;

   // CORDIC datapath width and start vector (0.6072529350 in Q2.30)
   localparam int TRIG_W = 33;
   localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 33'sd652032874;

   // configuration register indexes
   localparam logic [7:0] CSR_GAIN     = 8'd0;
   localparam logic [7:0] CSR_DISTANCE = 8'd1;
   localparam logic [7:0] CSR_START    = 8'd2;
   localparam logic [7:0] CSR_STEP     = 8'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAG_DIV,
      ST_MAG_SQRT,
      ST_MAG_MUL,
      ST_TRIG,
      ST_MUL_X,
      ST_MUL_Y,
      ST_ACC_Y,
      ST_MEAN_X_GO,
      ST_MEAN_X,
      ST_MEAN_Y_GO,
      ST_MEAN_Y,
      ST_EMIT
   } state_type;

   // divider request: remainder preload, dividend shifted in msb first
   typedef struct packed {
      logic        start;
      logic [31:0] rem_init;
      logic [39:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   // arctangent table, 32-bit binary angle
   function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
      logic signed [31:0] val;
      case (idx)
         5'd0:  val = 32'sd536870912;
         5'd1:  val = 32'sd316933406;
         5'd2:  val = 32'sd167458907;
         5'd3:  val = 32'sd85004756;
         5'd4:  val = 32'sd42667331;
         5'd5:  val = 32'sd21354465;
         5'd6:  val = 32'sd10679838;
         5'd7:  val = 32'sd5340245;
         5'd8:  val = 32'sd2670163;
         5'd9:  val = 32'sd1335087;
         5'd10: val = 32'sd667544;
         5'd11: val = 32'sd333772;
         5'd12: val = 32'sd166886;
         5'd13: val = 32'sd83443;
         5'd14: val = 32'sd41722;
         5'd15: val = 32'sd20861;
         5'd16: val = 32'sd10430;
         5'd17: val = 32'sd5215;
         5'd18: val = 32'sd2608;
         5'd19: val = 32'sd1304;
         5'd20: val = 32'sd652;
         5'd21: val = 32'sd326;
         5'd22: val = 32'sd163;
         5'd23: val = 32'sd81;
         default: val = 32'sd0;
      endcase
      return val;
   endfunction

   // saturate a mean quotient to 16 bits and restore the sign in 17 bits
   function automatic logic [16:0] mean_word(input logic [39:0] quot, input logic neg);
      logic [15:0] sat;
      logic [16:0] mag;
      sat = (|quot[39:16]) ? 16'hFFFF : quot[15:0];
      mag = {1'b0, sat};
      return neg ? (17'd0 - mag) : mag;
   endfunction

endpackage

// ===== rtl/srf_div.sv =====
// srf_div: restoring divider, one quotient bit per cycle, shared by magnitude and mean.
// Depends on srf_pkg.
`timescale 1ns / 1ps
module srf_div (
   input  logic                clock,
   input  logic                reset,
   input  srf_pkg::div_req_type req,
   output logic                done,
   output logic [39:0]         quotient
);

   logic [31:0] rem_ff, rem_in;
   logic [39:0] dvd_ff, dvd_in;
   logic [31:0] den_ff, den_in;
   logic [39:0] quot_ff, quot_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [32:0] diff;
   logic        ge;

   // one trial subtraction
   always_comb begin
      trial = {rem_ff, dvd_ff[39]};
      diff  = trial - {1'b0, den_ff};
      ge    = (trial >= {1'b0, den_ff});
   end

   // step sequencing
   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.rem_init;
         dvd_in  = req.dividend;
         den_in  = req.divisor;
         quot_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[31:0] : trial[31:0];
         dvd_in  = {dvd_ff[38:0], 1'b0};
         quot_in = {quot_ff[38:0], ge};
         cnt_in  = cnt_ff + 6'd1;
         if (cnt_ff == 6'(srf_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== rtl/srf_sqrt.sv =====
// srf_sqrt: digit-by-digit integer square root, one root bit per cycle.
// Depends on srf_pkg.
`timescale 1ns / 1ps
module srf_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [39:0] value,
   output logic        done,
   output logic [19:0] root
);

   logic [39:0] val_ff, val_in;
   logic [20:0] rem_ff, rem_in;
   logic [19:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [22:0] cur;
   logic [22:0] trial;
   logic [22:0] diff;
   logic        ge;

   // trial subtraction of 4*root+1
   always_comb begin
      cur   = {rem_ff, val_ff[39:38]};
      trial = {1'b0, root_ff, 2'b01};
      diff  = cur - trial;
      ge    = (cur >= trial);
   end

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in  = {val_ff[37:0], 2'b00};
         rem_in  = ge ? diff[20:0] : cur[20:0];
         root_in = {root_ff[18:0], ge};
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'(srf_pkg::SQRT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== rtl/srf_cordic.sv =====
// srf_cordic: rotation-mode CORDIC, one micro-rotation per cycle, cos and sin in Q2.30.
// Depends on srf_pkg.
`timescale 1ns / 1ps
module srf_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [15:0]                         angle,
   output logic                                done,
   output logic signed [srf_pkg::TRIG_W-1:0]   cos_out,
   output logic signed [srf_pkg::TRIG_W-1:0]   sin_out
);

   logic signed [srf_pkg::TRIG_W-1:0] x_ff, x_in;
   logic signed [srf_pkg::TRIG_W-1:0] y_ff, y_in;
   logic signed [srf_pkg::TRIG_W-1:0] z_ff, z_in;
   logic signed [srf_pkg::TRIG_W-1:0] x_sh, y_sh, atan_ext;
   logic        flip_ff, flip_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [15:0] quarter;
   logic [15:0] folded;
   logic        flip_now;

   // fold into [-1/4, 1/4) turn
   always_comb begin
      quarter  = angle + 16'h4000;
      flip_now = quarter[15];
      folded   = flip_now ? (angle ^ 16'h8000) : angle;
   end

   // shifted terms, arithmetic shift floors toward minus infinity
   always_comb begin
      x_sh     = x_ff >>> cnt_ff;
      y_sh     = y_ff >>> cnt_ff;
      atan_ext = srf_pkg::TRIG_W'(srf_pkg::atan_entry(cnt_ff));
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = srf_pkg::CORDIC_X0;
         y_in    = '0;
         z_in    = {folded[15], folded, 16'd0};
         flip_in = flip_now;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[srf_pkg::TRIG_W-1]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_ext;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_ext;
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(srf_pkg::TRIG_ITERATIONS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   // undo the half-turn fold
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;
   assign done    = done_ff;

endmodule

// ===== rtl/scan_repulsive_force_top.sv =====
// scan_repulsive_force_top: one beam per word. A beam in range takes 40 divider steps, 20
// square-root steps, 16 CORDIC rotations, multiply and accumulate; a zero range skips the
// divider and square root, one out of range skips to multiply, one past MAX_BEAMS is dropped.
// A last beam adds two 40-step mean divisions and any output register wait before its result.
// Synchronous active-high reset clears sums, beam count, sequencer and registers to defaults.
// Depends on srf_pkg, srf_div, srf_sqrt, srf_cordic.
`timescale 1ns / 1ps
module scan_repulsive_force_top (
   input  logic        clock,
   input  logic        reset,
   // beam words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // range_sample[15:0], heading[31:16]
   input  logic        req_tlast,   // last_sample
   // result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // force_x[16:0], force_y[33:17], zero fill
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   srf_pkg::state_type state_ff, state_in;

   logic [15:0] gain_ff, dist_ff, astart_ff, astep_ff;
   logic signed [47:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [srf_pkg::BEAM_W-1:0] beam_ff, beam_in;
   logic        last_ff, last_in;
   logic [15:0] angle_ff, angle_in;
   logic [15:0] mag_ff, mag_in;
   logic signed [49:0] prod_ff, prod_in;
   logic [16:0] fx_ff, fx_in, fy_ff, fy_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [33:0] rsp_data_ff, rsp_data_in;

   logic [15:0] range_w, head_w;
   logic [srf_pkg::BEAM_W+15:0] ang_prod;
   logic [31:0] den_prod;
   logic [35:0] gain_prod;
   logic signed [49:0] prod_sh;
   logic [47:0] abs_x, abs_y;
   logic        accept;

   srf_pkg::div_req_type div_req;
   logic        div_done;
   logic [39:0] div_quot;
   logic        sqrt_start, sqrt_done;
   logic [19:0] sqrt_root;
   logic        cordic_start, cordic_done;
   logic [15:0] cordic_angle;
   logic signed [srf_pkg::TRIG_W-1:0] cos_w, sin_w;

   srf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quot)
   );

   srf_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (div_quot),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   srf_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (cordic_angle),
      .done    (cordic_done),
      .cos_out (cos_w),
      .sin_out (sin_w)
   );

   // register writes, always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= 16'd12288;
         dist_ff   <= 16'd256;
         astart_ff <= 16'd0;
         astep_ff  <= 16'd0;
      end else if (csr_valid) begin
         case (csr_index)
            srf_pkg::CSR_GAIN:     gain_ff   <= csr_data;
            srf_pkg::CSR_DISTANCE: dist_ff   <= csr_data;
            srf_pkg::CSR_START:    astart_ff <= csr_data;
            srf_pkg::CSR_STEP:     astep_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // datapath helpers
   always_comb begin
      range_w   = req_tdata[15:0];
      head_w    = req_tdata[31:16];
      ang_prod  = beam_ff * astep_ff;
      den_prod  = range_w * dist_ff;
      gain_prod = gain_ff * sqrt_root;
      prod_sh   = prod_ff >>> 16;
      abs_x     = sum_x_ff[47] ? 48'(-sum_x_ff) : 48'(sum_x_ff);
      abs_y     = sum_y_ff[47] ? 48'(-sum_y_ff) : 48'(sum_y_ff);
      accept    = req_tvalid && req_tready;
   end

   assign req_tready = (state_ff == srf_pkg::ST_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      beam_in      = beam_ff;
      last_in      = last_ff;
      angle_in     = angle_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      div_req      = '0;
      sqrt_start   = 1'b0;
      cordic_start = 1'b0;
      cordic_angle = angle_ff;
      case (state_ff)
         srf_pkg::ST_IDLE: begin
            if (accept) begin
               last_in  = req_tlast;
               angle_in = astart_ff + ang_prod[15:0] + head_w;
               if (beam_ff == srf_pkg::BEAM_W'(srf_pkg::MAX_BEAMS)) begin
                  state_in = req_tlast ? srf_pkg::ST_MEAN_X_GO : srf_pkg::ST_IDLE;
               end else if (range_w >= dist_ff) begin
                  // out of influence: zero term, still counted
                  mag_in   = 16'd0;
                  state_in = srf_pkg::ST_MUL_X;
               end else if (range_w == 16'd0) begin
                  mag_in       = 16'hFFFF;
                  cordic_start = 1'b1;
                  cordic_angle = astart_ff + ang_prod[15:0] + head_w;
                  state_in     = srf_pkg::ST_TRIG;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.rem_init = {16'd0, dist_ff - range_w};
                  div_req.dividend = '0;
                  div_req.divisor  = den_prod;
                  state_in         = srf_pkg::ST_MAG_DIV;
               end
            end
         end
         srf_pkg::ST_MAG_DIV: begin
            if (div_done) begin
               sqrt_start = 1'b1;
               state_in   = srf_pkg::ST_MAG_SQRT;
            end
         end
         srf_pkg::ST_MAG_SQRT: begin
            if (sqrt_done) begin
               state_in = srf_pkg::ST_MAG_MUL;
            end
         end
         srf_pkg::ST_MAG_MUL: begin
            mag_in       = gain_prod[35:20];
            cordic_start = 1'b1;
            state_in     = srf_pkg::ST_TRIG;
         end
         srf_pkg::ST_TRIG: begin
            if (cordic_done) begin
               state_in = srf_pkg::ST_MUL_X;
            end
         end
         srf_pkg::ST_MUL_X: begin
            prod_in  = $signed({1'b0, mag_ff}) * cos_w;
            state_in = srf_pkg::ST_MUL_Y;
         end
         srf_pkg::ST_MUL_Y: begin
            sum_x_in = sum_x_ff - prod_sh[47:0];
            prod_in  = $signed({1'b0, mag_ff}) * sin_w;
            state_in = srf_pkg::ST_ACC_Y;
         end
         srf_pkg::ST_ACC_Y: begin
            sum_y_in = sum_y_ff - prod_sh[47:0];
            beam_in  = beam_ff + 1'b1;
            state_in = last_ff ? srf_pkg::ST_MEAN_X_GO : srf_pkg::ST_IDLE;
         end
         srf_pkg::ST_MEAN_X_GO: begin
            div_req.start    = 1'b1;
            div_req.rem_init = '0;
            div_req.dividend = {6'd0, abs_x[47:14]};
            div_req.divisor  = 32'(beam_ff);
            state_in         = srf_pkg::ST_MEAN_X;
         end
         srf_pkg::ST_MEAN_X: begin
            if (div_done) begin
               fx_in    = srf_pkg::mean_word(div_quot, sum_x_ff[47]);
               state_in = srf_pkg::ST_MEAN_Y_GO;
            end
         end
         srf_pkg::ST_MEAN_Y_GO: begin
            div_req.start    = 1'b1;
            div_req.rem_init = '0;
            div_req.dividend = {6'd0, abs_y[47:14]};
            div_req.divisor  = 32'(beam_ff);
            state_in         = srf_pkg::ST_MEAN_Y;
         end
         srf_pkg::ST_MEAN_Y: begin
            if (div_done) begin
               fy_in    = srf_pkg::mean_word(div_quot, sum_y_ff[47]);
               state_in = srf_pkg::ST_EMIT;
            end
         end
         srf_pkg::ST_EMIT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {fy_ff, fx_ff};
               rsp_valid_in = 1'b1;
               sum_x_in     = '0;
               sum_y_in     = '0;
               beam_in      = '0;
               state_in     = srf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srf_pkg::ST_IDLE;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         beam_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         beam_ff      <= beam_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff     <= last_in;
      angle_ff    <= angle_in;
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      fx_ff       <= fx_in;
      fy_ff       <= fy_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

`ifndef SYNTHESIS
   a_beam_bound: assert property (@(posedge clock) disable iff (reset)
      beam_ff <= srf_pkg::BEAM_W'(srf_pkg::MAX_BEAMS))
      else $error("beam count past maximum");

   a_div_to_sqrt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srf_pkg::ST_MAG_DIV && div_done) |=> state_ff == srf_pkg::ST_MAG_SQRT)
      else $error("magnitude quotient not passed to square root");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (beam_ff == '0 && sum_x_ff == '0 && sum_y_ff == '0))
      else $error("scan state not cleared with result word");

   // a dropped beam past the maximum that does not close the scan keeps ready high
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (beam_ff != srf_pkg::BEAM_W'(srf_pkg::MAX_BEAMS) || req_tlast))
      |=> !req_tready)
      else $error("ready while a beam is in work");
`endif

endmodule

// ===== tb/testbench.sv =====
// testbench: drives beam words into scan_repulsive_force_top and checks each mean force
// word against a bit-accurate force predictor. Depends on srf_pkg and the block's RTL.
`timescale 1ns / 1ps
module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   scan_repulsive_force_top i_dut (.*);

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of registers and scan state
   logic [15:0] gain_q = 16'd12288, dist_q = 16'd256, start_q = '0, step_q = '0;
   longint      acc_x = 0, acc_y = 0;
   int unsigned beams_held = 0;
   logic [16:0] force_x_q[$], force_y_q[$];
   int          errors = 0;
   int          burst_left = 0;
   bit          stall_on = 1'b0;
   bit          fixed_beams = 1'b0;

   task automatic report(input string what, input logic [16:0] got, input logic [16:0] want);
      errors++;
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
   endtask

   function automatic longint shr_floor(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint beam_magnitude(input longint r, input longint d0,
                                             input longint g);
      longint unsigned v, s, bitv, m;
      if (r >= d0) return 0;
      if (r == 0) return 65535;
      v = (longint'(d0 - r) << 40) / longint'(r * d0);
      s = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= s + bitv) begin
            v -= s + bitv;
            s = (s >> 1) + bitv;
         end else s >>= 1;
         bitv >>= 2;
      end
      m = (longint'(g) * s) >> 20;
      return (m > 65535) ? 65535 : m;
   endfunction

   task automatic rotate(input logic [15:0] a, output longint c, output longint s);
      longint x, y, z, nx;
      bit     flip;
      logic [15:0] aa;
      x = 652032874;
      y = 0;
      aa = a;
      flip = aa[15] ^ aa[14];
      if (flip) aa = aa ^ 16'h8000;
      z = longint'($signed(aa)) * 65536;
      for (int i = 0; i < srf_pkg::TRIG_ITERATIONS; i++) begin
         if (z >= 0) begin
            nx = x - shr_floor(y, i);
            y = y + shr_floor(x, i);
            z -= longint'(srf_pkg::atan_entry(i[4:0]));
         end else begin
            nx = x + shr_floor(y, i);
            y = y - shr_floor(x, i);
            z += longint'(srf_pkg::atan_entry(i[4:0]));
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic logic [16:0] scan_mean(input longint sum, input int unsigned n);
      longint unsigned mag, q;
      mag = (sum < 0) ? -sum : sum;
      q = mag / (longint'(n) << 14);
      if (q > 65535) q = 65535;
      return (sum < 0) ? 17'(-longint'(q)) : 17'(q);
   endfunction

   task automatic predict_beam(input logic [15:0] r, input logic [15:0] head, input bit last);
      longint m, c, s;
      logic [15:0] ang;
      if (beams_held < srf_pkg::MAX_BEAMS) begin
         m = beam_magnitude(r, dist_q, gain_q);
         ang = start_q + 16'(beams_held * step_q) + head;
         rotate(ang, c, s);
         acc_x -= shr_floor(m * c, 16);
         acc_y -= shr_floor(m * s, 16);
         beams_held++;
      end
      if (last) begin
         force_x_q = {force_x_q, scan_mean(acc_x, beams_held)};
         force_y_q = {force_y_q, scan_mean(acc_y, beams_held)};
         acc_x = 0;
         acc_y = 0;
         beams_held = 0;
      end
   endtask

   // receiver stall pattern and result checking
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (force_x_q.size() == 0) begin
            report("unexpected force word", rsp_tdata[16:0], '0);
         end else begin
            if (rsp_tdata[16:0] !== force_x_q[0])
               report("force_x", rsp_tdata[16:0], force_x_q[0]);
            if (rsp_tdata[33:17] !== force_y_q[0])
               report("force_y", rsp_tdata[33:17], force_y_q[0]);
            void'(force_x_q.pop_front());
            void'(force_y_q.pop_front());
         end
      end
   end
   always @(negedge clock)
      rsp_tready <= stall_on ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
   always @(negedge clock)
      if ($urandom_range(0, 199) == 0) stall_on <= ~stall_on;

   // send one beam word, with burst gaps
   task automatic send_beam(input logic [15:0] r, input logic [15:0] head, input bit last);
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tdata = {head, r};
      req_tlast = last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_beam(r, head, last);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic drain;
      while (force_x_q.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         srf_pkg::CSR_GAIN:     gain_q = val;
         srf_pkg::CSR_DISTANCE: dist_q = val;
         srf_pkg::CSR_START:    start_q = val;
         srf_pkg::CSR_STEP:     step_q = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [15:0] rand_range_word;
      case ($urandom_range(0, 5))
         0: return 16'(dist_q - $urandom_range(0, 3));
         1: return 16'($urandom_range(0, 8));
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, dist_q));
      endcase
   endfunction

   // edge cases: zero range, at and past distance, extremes, big gain, zero distance
   task automatic test_directed;
      send_beam(16'd0, 16'd0, 1'b0);
      send_beam(16'd256, 16'h4000, 1'b0);
      send_beam(16'd1, 16'h8000, 1'b0);
      send_beam(16'd255, 16'hC000, 1'b0);
      send_beam(16'hFFFF, 16'h7FFF, 1'b1);
      send_beam(16'd0, 16'hFFFF, 1'b1);
      drain();
      write_reg(srf_pkg::CSR_GAIN, 16'hFFFF);
      write_reg(srf_pkg::CSR_DISTANCE, 16'hFFFF);
      write_reg(srf_pkg::CSR_START, 16'h8000);
      write_reg(srf_pkg::CSR_STEP, 16'h7FFF);
      write_reg(8'hFF, 16'h1234);
      for (int i = 0; i < 6; i++) send_beam(16'(1 << (2 * i)), 16'(i * 9000), i == 5);
      send_beam(16'hFFFE, 16'h2000, 1'b1);
      drain();
      write_reg(srf_pkg::CSR_DISTANCE, 16'd0);
      send_beam(16'd0, 16'd0, 1'b0);
      send_beam(16'd5, 16'd100, 1'b1);
      drain();
   endtask

   // one scan past MAX_BEAMS, mostly cheap out-of-range beams
   task automatic test_overflow;
      write_reg(srf_pkg::CSR_DISTANCE, 16'd512);
      write_reg(srf_pkg::CSR_GAIN, 16'd12288);
      write_reg(srf_pkg::CSR_STEP, 16'd64);
      for (int i = 0; i < srf_pkg::MAX_BEAMS + 3; i++)
         send_beam((i % 97 == 0) ? 16'(i % 400) : 16'hF000, 16'($urandom),
                   i == srf_pkg::MAX_BEAMS + 2);
      drain();
   endtask

   // random scans over several register settings
   task automatic test_random;
      int sent;
      sent = 0;
      while (sent < 900) begin
         write_reg(srf_pkg::CSR_GAIN,
                   ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom));
         write_reg(srf_pkg::CSR_DISTANCE,
                   ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 2048)));
         write_reg(srf_pkg::CSR_START, 16'($urandom));
         write_reg(srf_pkg::CSR_STEP,
                   ($urandom_range(0, 4) == 0) ? 16'h8000 : 16'($urandom));
         for (int s = 0; s < 8; s++) begin
            int len;
            len = $urandom_range(1, 14);
            for (int b = 0; b < len; b++) begin
               send_beam(rand_range_word(), 16'($urandom), b == len - 1);
               sent++;
            end
         end
         drain();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_overflow();
      test_random();
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // hard stop
   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
